FILE: hdl/sba_pkg.sv
// sba_pkg: shared constants, field widths, sequencer states and control structs
// for the stft bin analysis block. No dependencies.
`default_nettype none

package sba_pkg;

  // default configuration of the block
  localparam int N_FFT_DEF    = 2048;
  localparam int HOP_DEF      = 512;
  localparam int CHUNK_DEF    = 262144;
  localparam int CHANNELS_DEF = 2;
  localparam int PAD_DEF      = 1024;

  // field widths
  localparam int SAMPLE_W   = 16;
  localparam int CH_W       = 1;
  localparam int SIDX_W     = 18;
  localparam int FRAME_W    = 10;
  localparam int BIN_W      = 11;
  localparam int OUT_W      = 28;
  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 56;

  // action codes carried on in_tuser
  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_BIN   = 1'b1;

  // sequencer states
  typedef enum logic [2:0] {
    ST_FILL,
    ST_IDLE,
    ST_REDUCE,
    ST_RUN,
    ST_DRAIN,
    ST_PUT
  } sba_state_t;

  // tag that travels with each sample read into the mac pipeline
  typedef struct packed {
    logic vld;
    logic first;
    logic last;
  } sba_tap_t;

  // result register control from the sequencer
  typedef struct packed {
    logic load;
    logic zero;
  } sba_put_t;

endpackage

`default_nettype wire

FILE: hdl/stft_bin_analysis.sv
// stft_bin_analysis: top level; sample store, window and twiddle memories, sequencer,
// mac unit and result register. Depends on sba_pkg, sba_ram, sba_seq, sba_mac.
// Sample write: taken on any transfer while in_tready is high. Bin request: the samples
// pass one a cycle through the shared mac unit; the next transfer is taken once the
// result sits in the output register.
// Request with channel or frame out of range: result of zeros, with no mac pass.
// Reset (rst_n low, synchronous): a fill pass writes all N_FFT table entries, in_tready low.
`default_nettype none

module stft_bin_analysis import sba_pkg::*; #(
  parameter int N_FFT         = N_FFT_DEF,
  parameter int HOP           = HOP_DEF,
  parameter int CHUNK_SAMPLES = CHUNK_DEF,
  parameter int CHANNELS      = CHANNELS_DEF,
  parameter int PAD           = PAD_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  // channel, sample_index, sample_value, frame_index, bin_index
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  // action
  input  wire logic                  in_tuser,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // real_part, imag_part
  output logic      [OUT_DATA_W-1:0] out_tdata
);

  localparam int MW  = $clog2(N_FFT);
  localparam int SAW = $clog2(CHANNELS * CHUNK_SAMPLES);
  localparam logic [SAW-1:0] CH_OFS = SAW'(CHUNK_SAMPLES);

  localparam longint unsigned ONE_Q30     = 64'd1073741824;
  localparam longint          ONE_Q30S    = 64'sd1073741824;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  typedef logic signed [SAMPLE_W-1:0] tab_t [N_FFT];

  // taylor term divisor per step
  function automatic longint unsigned div_term(input longint unsigned t, input int i,
                                               input bit odd);
    case (i)
      1:       return odd ? t / 6   : t / 2;
      2:       return odd ? t / 20  : t / 12;
      3:       return odd ? t / 42  : t / 30;
      4:       return odd ? t / 72  : t / 56;
      5:       return odd ? t / 110 : t / 90;
      6:       return odd ? t / 156 : t / 132;
      7:       return odd ? t / 210 : t / 182;
      8:       return odd ? t / 272 : t / 240;
      9:       return odd ? t / 342 : t / 306;
      default: return odd ? t / 420 : t / 380;
    endcase
  endfunction

  // q30 taylor series on the first quadrant, odd selects sine
  function automatic longint series_q30(input longint unsigned x, input bit odd);
    longint unsigned x2;
    longint unsigned term;
    longint          acc;
    x2   = (x * x) >> 30;
    term = odd ? x : ONE_Q30;
    acc  = longint'(term);
    for (int i = 1; i <= 10; i++) begin
      term = div_term((term * x2) >> 30, i, odd);
      if ((i & 1) != 0) acc -= longint'(term);
      else acc += longint'(term);
    end
    return acc;
  endfunction

  // cos(2 pi m / n_fft) in q30
  function automatic longint cos_q30(input int m);
    longint unsigned r4;
    longint unsigned phi;
    int              q;
    r4  = 64'(4 * (m % N_FFT));
    q   = int'((r4 / N_FFT) & 64'd3);
    phi = (HALF_PI_Q30 * (r4 % N_FFT)) / N_FFT;
    case (q)
      0:       return series_q30(phi, 1'b0);
      1:       return -series_q30(phi, 1'b1);
      2:       return -series_q30(phi, 1'b0);
      default: return series_q30(phi, 1'b1);
    endcase
  endfunction

  // q30 to q15, half away from zero, saturating
  function automatic logic signed [SAMPLE_W-1:0] q30_to_q15(input longint v);
    bit              neg;
    longint unsigned mag;
    neg = v < 0;
    mag = neg ? -v : v;
    mag = (mag + 64'd16384) >> 15;
    if (neg) begin
      return (mag > 64'd32768) ? 16'h8000 : 16'(-longint'(mag));
    end
    return (mag > 64'd32767) ? 16'h7fff : 16'(mag);
  endfunction

  function automatic tab_t build_cos();
    tab_t t;
    for (int n = 0; n < N_FFT; n++) begin
      t[n] = q30_to_q15(cos_q30(n));
    end
    return t;
  endfunction

  function automatic tab_t build_win();
    tab_t t;
    for (int n = 0; n < N_FFT; n++) begin
      t[n] = q30_to_q15((ONE_Q30S - cos_q30(n)) / 2);
    end
    return t;
  endfunction

  localparam tab_t COS_TAB = build_cos();
  localparam tab_t WIN_TAB = build_win();

  // input fields
  logic [CH_W-1:0]     f_ch;
  logic [SIDX_W-1:0]   f_sidx;
  logic [SAMPLE_W-1:0] f_sval;
  logic [FRAME_W-1:0]  f_frame;
  logic [BIN_W-1:0]    f_bin;

  assign f_ch    = in_tdata[0 +: CH_W];
  assign f_sidx  = in_tdata[CH_W +: SIDX_W];
  assign f_sval  = in_tdata[CH_W + SIDX_W +: SAMPLE_W];
  assign f_frame = in_tdata[CH_W + SIDX_W + SAMPLE_W +: FRAME_W];
  assign f_bin   = in_tdata[CH_W + SIDX_W + SAMPLE_W + FRAME_W +: BIN_W];

  logic                in_xfer;
  logic                smp_we;
  logic [SAW-1:0]      smp_waddr;
  logic                req_go;
  logic                idle;
  logic                tab_we;
  logic [MW-1:0]       tab_waddr;
  logic [SAW-1:0]      smp_raddr;
  logic [MW-1:0]       win_raddr, cos_raddr, sin_raddr;
  logic [SAMPLE_W-1:0] x_rd, w_rd, c_rd, s_rd;
  sba_tap_t            tap;
  sba_put_t            put;
  logic                mac_done;
  logic signed [OUT_W-1:0] res_re, res_im;

  logic                    out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0]   out_data_r;
  logic                    out_free;

  // input transfer decode
  assign in_tready = idle;
  assign in_xfer   = in_tvalid && in_tready;
  assign req_go    = in_xfer && (in_tuser == ACT_BIN);
  assign smp_we    = in_xfer && (in_tuser == ACT_WRITE)
                     && (int'(f_sidx) < CHUNK_SAMPLES) && (int'(f_ch) < CHANNELS);
  assign smp_waddr = SAW'(f_sidx) + ((f_ch != '0) ? CH_OFS : '0);

  // sample store
  sba_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (CHANNELS * CHUNK_SAMPLES)
  ) u_smp_ram (
    .clk   (clk),
    .we    (smp_we),
    .waddr (smp_waddr),
    .wdata (f_sval),
    .raddr (smp_raddr),
    .rdata (x_rd)
  );

  // window table
  sba_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (N_FFT)
  ) u_win_ram (
    .clk   (clk),
    .we    (tab_we),
    .waddr (tab_waddr),
    .wdata (WIN_TAB[tab_waddr]),
    .raddr (win_raddr),
    .rdata (w_rd)
  );

  // cosine table, cosine read port
  sba_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (N_FFT)
  ) u_cos_ram (
    .clk   (clk),
    .we    (tab_we),
    .waddr (tab_waddr),
    .wdata (COS_TAB[tab_waddr]),
    .raddr (cos_raddr),
    .rdata (c_rd)
  );

  // cosine table copy, read a quarter period back for sine
  sba_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (N_FFT)
  ) u_sin_ram (
    .clk   (clk),
    .we    (tab_we),
    .waddr (tab_waddr),
    .wdata (COS_TAB[tab_waddr]),
    .raddr (sin_raddr),
    .rdata (s_rd)
  );

  sba_seq #(
    .N_FFT         (N_FFT),
    .HOP           (HOP),
    .CHUNK_SAMPLES (CHUNK_SAMPLES),
    .CHANNELS      (CHANNELS),
    .PAD           (PAD)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_go    (req_go),
    .req_ch    (f_ch),
    .req_frame (f_frame),
    .req_bin   (f_bin),
    .mac_done  (mac_done),
    .out_free  (out_free),
    .idle      (idle),
    .tab_we    (tab_we),
    .tab_waddr (tab_waddr),
    .smp_raddr (smp_raddr),
    .win_raddr (win_raddr),
    .cos_raddr (cos_raddr),
    .sin_raddr (sin_raddr),
    .tap       (tap),
    .put       (put)
  );

  sba_mac #(
    .N_FFT (N_FFT)
  ) u_mac (
    .clk    (clk),
    .rst_n  (rst_n),
    .tap    (tap),
    .x      (x_rd),
    .w      (w_rd),
    .c      (c_rd),
    .s      (s_rd),
    .done   (mac_done),
    .res_re (res_re),
    .res_im (res_im)
  );

  // output register
  assign out_free = !out_valid_r || out_tready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (put.load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (put.load) begin
      out_data_r <= put.zero ? '0 : {res_im, res_re};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

`default_nettype wire

FILE: hdl/sba_ram.sv
// sba_ram: generic simple dual-port RAM, one write port, one registered read port.
// No dependencies.
`default_nettype none

module sba_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

FILE: hdl/sba_seq.sv
// sba_seq: sequencer for table fill, bin reduction, per-sample address generation
// with reflect padding, and result hand-off. Depends on sba_pkg.
`default_nettype none

module sba_seq import sba_pkg::*; #(
  parameter int N_FFT         = N_FFT_DEF,
  parameter int HOP           = HOP_DEF,
  parameter int CHUNK_SAMPLES = CHUNK_DEF,
  parameter int CHANNELS      = CHANNELS_DEF,
  parameter int PAD           = PAD_DEF
) (
  input  wire logic                                        clk,
  input  wire logic                                        rst_n,
  input  wire logic                                        req_go,
  input  wire logic [CH_W-1:0]                             req_ch,
  input  wire logic [FRAME_W-1:0]                          req_frame,
  input  wire logic [BIN_W-1:0]                            req_bin,
  input  wire logic                                        mac_done,
  input  wire logic                                        out_free,
  output logic                                             idle,
  output logic                                             tab_we,
  output logic      [$clog2(N_FFT)-1:0]                    tab_waddr,
  output logic      [$clog2(CHANNELS*CHUNK_SAMPLES)-1:0]   smp_raddr,
  output logic      [$clog2(N_FFT)-1:0]                    win_raddr,
  output logic      [$clog2(N_FFT)-1:0]                    cos_raddr,
  output logic      [$clog2(N_FFT)-1:0]                    sin_raddr,
  output sba_tap_t                                         tap,
  output sba_put_t                                         put
);

  localparam int MW        = $clog2(N_FFT);
  localparam int SAW       = $clog2(CHANNELS * CHUNK_SAMPLES);
  localparam int FRAMES    = CHUNK_SAMPLES / HOP + 1;
  localparam int FRAME_MAX = 2**FRAME_W - 1;
  localparam int POS_W     = $clog2(2 * CHUNK_SAMPLES + FRAME_MAX * HOP + N_FFT + PAD) + 1;

  localparam logic [MW:0]   N_EXT   = (MW+1)'(N_FFT);
  localparam logic [MW:0]   SIN_OFS = (MW+1)'(N_FFT - N_FFT / 4);
  localparam logic [MW-1:0] N_LAST  = MW'(N_FFT - 1);

  localparam logic signed [POS_W-1:0] POS_C   = POS_W'(CHUNK_SAMPLES);
  localparam logic signed [POS_W-1:0] POS_C2  = POS_W'(2 * CHUNK_SAMPLES - 2);
  localparam logic signed [POS_W-1:0] POS_CM1 = POS_W'(CHUNK_SAMPLES - 1);
  localparam logic signed [POS_W-1:0] POS_ONE = POS_W'(1);
  localparam logic [SAW-1:0]          CH_OFS  = SAW'(CHUNK_SAMPLES);

  sba_state_t state_r, state_nxt;

  logic [MW-1:0]             fill_r, fill_nxt;
  logic [MW-1:0]             n_r, n_nxt;
  logic [MW-1:0]             m_r, m_nxt;
  logic [BIN_W-1:0]          k_r, k_nxt;
  logic signed [POS_W-1:0]   pos_r, pos_nxt;
  logic [CH_W-1:0]           ch_r, ch_nxt;
  logic                      zero_r, zero_nxt;

  logic                      req_ok;
  logic                      k_big;
  logic                      n_last;
  logic [MW:0]               msum, ssum;
  logic signed [POS_W-1:0]   p1, p2, p3;

  assign req_ok = (int'(req_ch) < CHANNELS) && (int'(req_frame) < FRAMES);
  assign k_big  = int'(k_r) >= N_FFT;
  assign n_last = n_r == N_LAST;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_FILL: begin
        if (fill_r == N_LAST) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (req_go) state_nxt = req_ok ? ST_REDUCE : ST_PUT;
      end
      ST_REDUCE: begin
        if (!k_big) state_nxt = ST_RUN;
      end
      ST_RUN: begin
        if (n_last) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (mac_done) state_nxt = ST_PUT;
      end
      ST_PUT: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    idle      = state_r == ST_IDLE;
    tab_we    = state_r == ST_FILL;
    tab_waddr = fill_r;
    tap.vld   = state_r == ST_RUN;
    tap.first = n_r == '0;
    tap.last  = n_last;
    put.load  = (state_r == ST_PUT) && out_free;
    put.zero  = zero_r;
  end

  // twiddle indices, m + k and m + 3n/4 reduced once
  always_comb begin
    msum = {1'b0, m_r} + {1'b0, MW'(k_r)};
    ssum = {1'b0, m_r} + SIN_OFS;
    cos_raddr = m_r;
    sin_raddr = (ssum >= N_EXT) ? MW'(ssum - N_EXT) : MW'(ssum);
    win_raddr = n_r;
  end

  // reflect padding and clamp, then channel offset
  always_comb begin
    p1 = (pos_r < 0) ? -pos_r : pos_r;
    p2 = (p1 >= POS_C) ? POS_C2 - p1 : p1;
    if (p2 < 0) begin
      p3 = '0;
    end else if (p2 >= POS_C) begin
      p3 = POS_CM1;
    end else begin
      p3 = p2;
    end
    smp_raddr = SAW'(p3) + ((ch_r != '0) ? CH_OFS : '0);
  end

  // counters and request registers
  always_comb begin
    int start;
    start    = int'(req_frame) * HOP - PAD;
    fill_nxt = fill_r;
    n_nxt    = n_r;
    m_nxt    = m_r;
    k_nxt    = k_r;
    pos_nxt  = pos_r;
    ch_nxt   = ch_r;
    zero_nxt = zero_r;
    case (state_r)
      ST_FILL: begin
        fill_nxt = fill_r + 1'b1;
      end
      ST_IDLE: begin
        if (req_go) begin
          k_nxt    = req_bin;
          pos_nxt  = POS_W'(start);
          ch_nxt   = req_ch;
          zero_nxt = !req_ok;
        end
      end
      ST_REDUCE: begin
        if (k_big) k_nxt = k_r - BIN_W'(N_FFT);
        n_nxt = '0;
        m_nxt = '0;
      end
      ST_RUN: begin
        n_nxt   = n_r + 1'b1;
        m_nxt   = (msum >= N_EXT) ? MW'(msum - N_EXT) : MW'(msum);
        pos_nxt = pos_r + POS_ONE;
      end
      default: begin
      end
    endcase
  end

  // state and counter registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_FILL;
      fill_r  <= '0;
      n_r     <= '0;
      m_r     <= '0;
      k_r     <= '0;
      pos_r   <= '0;
      ch_r    <= '0;
      zero_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      n_r     <= n_nxt;
      m_r     <= m_nxt;
      k_r     <= k_nxt;
      pos_r   <= pos_nxt;
      ch_r    <= ch_nxt;
      zero_r  <= zero_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/sba_mac.sv
// sba_mac: shared complex multiply-accumulate unit: window multiply with rounding,
// cos/sin products, accumulation, final rounding and saturation. Depends on sba_pkg.
`default_nettype none

module sba_mac import sba_pkg::*; #(
  parameter int N_FFT = N_FFT_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire sba_tap_t                   tap,
  input  wire logic signed [SAMPLE_W-1:0] x,
  input  wire logic signed [SAMPLE_W-1:0] w,
  input  wire logic signed [SAMPLE_W-1:0] c,
  input  wire logic signed [SAMPLE_W-1:0] s,
  output logic                            done,
  output logic signed [OUT_W-1:0]         res_re,
  output logic signed [OUT_W-1:0]         res_im
);

  localparam int ACC_W = 33 + $clog2(N_FFT);
  localparam logic signed [ACC_W-1:0] O_MAX = ACC_W'(2**(OUT_W-1) - 1);
  localparam logic signed [ACC_W-1:0] O_MIN = ACC_W'(-(2**(OUT_W-1)));
  localparam logic signed [ACC_W-1:0] RND   = ACC_W'(16384);

  sba_tap_t                    tap1_r, tap2_r, tap3_r;
  logic signed [16:0]          xw_r;
  logic signed [SAMPLE_W-1:0]  c2_r, s2_r;
  logic signed [32:0]          pre_r, pim_r;
  logic signed [ACC_W-1:0]     acc_re_r, acc_re_nxt;
  logic signed [ACC_W-1:0]     acc_im_r, acc_im_nxt;
  logic                        done4_r, done_r;
  logic signed [OUT_W-1:0]     res_re_r, res_im_r;

  logic signed [31:0]          xw_prod;
  logic signed [31:0]          xw_sum;
  logic signed [32:0]          pre_nxt, pim_nxt;

  // round a q30 sum to q15 (half up) and saturate to the result width
  function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [ACC_W-1:0] a);
    logic signed [ACC_W-1:0] q;
    q = (a + RND) >>> 15;
    if (q > O_MAX) begin
      return {1'b0, {(OUT_W-1){1'b1}}};
    end else if (q < O_MIN) begin
      return {1'b1, {(OUT_W-1){1'b0}}};
    end
    return q[OUT_W-1:0];
  endfunction

  // windowed sample, rounded half up to q15
  assign xw_prod = x * w;
  assign xw_sum  = xw_prod + 32'sd16384;

  // twiddle products
  assign pre_nxt = xw_r * c2_r;
  assign pim_nxt = xw_r * s2_r;

  // accumulation, restarted on the first sample
  always_comb begin
    acc_re_nxt = acc_re_r;
    acc_im_nxt = acc_im_r;
    if (tap3_r.vld) begin
      if (tap3_r.first) begin
        acc_re_nxt = ACC_W'(pre_r);
        acc_im_nxt = -ACC_W'(pim_r);
      end else begin
        acc_re_nxt = acc_re_r + ACC_W'(pre_r);
        acc_im_nxt = acc_im_r - ACC_W'(pim_r);
      end
    end
  end

  // pipeline payload
  always_ff @(posedge clk) begin
    xw_r     <= xw_sum[31:15];
    c2_r     <= c;
    s2_r     <= s;
    pre_r    <= pre_nxt;
    pim_r    <= pim_nxt;
    acc_re_r <= acc_re_nxt;
    acc_im_r <= acc_im_nxt;
    if (done4_r) begin
      res_re_r <= sat_out(acc_re_r);
      res_im_r <= sat_out(acc_im_r);
    end
  end

  // pipeline control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tap1_r  <= '0;
      tap2_r  <= '0;
      tap3_r  <= '0;
      done4_r <= 1'b0;
      done_r  <= 1'b0;
    end else begin
      tap1_r  <= tap;
      tap2_r  <= tap1_r;
      tap3_r  <= tap2_r;
      done4_r <= tap3_r.vld && tap3_r.last;
      done_r  <= done4_r;
    end
  end

  assign done   = done_r;
  assign res_re = res_re_r;
  assign res_im = res_im_r;

endmodule

`default_nettype wire
